### hw/rtl/abcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII bus command parser package
// Shared constants, codes and types of the controller and the datapath.
// ----------------------------------------------------------------------------
package abcp_pkg;

    // Command geometry.
    localparam int ADDR_CHARS = 4;
    localparam int SEQ_BYTES  = 16;

    localparam int ADDR_CNT_W = $clog2(ADDR_CHARS + 1);
    localparam int ADDR_IDX_W = $clog2(ADDR_CHARS);
    localparam int SEQ_IDX_W  = $clog2(SEQ_BYTES);

    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 4;

    // Characters that steer the parser.
    localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

    // Hex digit decoding offsets.
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
    localparam logic [CHAR_W-1:0] OFS_DIGIT  = 8'd48;
    localparam logic [CHAR_W-1:0] OFS_LETTER = 8'd55;

    // Command kind reported with every result.
    typedef enum logic [1:0] {
        KIND_RB = 2'd0,
        KIND_RS = 2'd1,
        KIND_WB = 2'd2,
        KIND_WS = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  addr_we;
        logic [ADDR_IDX_W-1:0] addr_idx;
        logic                  load_hi;
        logic                  add_lo;
        logic                  buf_we;
        logic [SEQ_IDX_W-1:0]  buf_idx;
        logic                  out_load;
        kind_t                 out_kind;
        logic [INDEX_W-1:0]    out_index;
        logic                  out_last;
    } abcp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_r;
        logic is_w;
        logic is_b;
        logic is_s;
        logic is_comma;
        logic is_hash;
        logic out_free;
    } abcp_stat_t;

    // Hex digit value without validation, modulo 256.
    function automatic logic [CHAR_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] ofs;
        ofs = (c <= CH_NINE) ? OFS_DIGIT : OFS_LETTER;
        return c - ofs;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ascii_bus_command_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII bus command parser
// Parses RB, RS, WB and WS commands from a character stream into bus results.
// ----------------------------------------------------------------------------
// The parser takes one character word per cycle on the slave side while it is
// idle, parsing or waiting for '#'. When a command completes, the controller
// enters a drain phase in which the slave side is held off: the result words
// are moved one per cycle, unless the master side stalls, through a single
// output register, one word for RB, RS and WB and sixteen words for WS, read
// out of the sequence buffer in order. The slave side reopens in the cycle
// after the last word is loaded, even while that word still waits in the
// output register. The sequence buffer needs no clearing pass after reset,
// since a WS command writes every entry it reads. After a result the parser
// ignores every character up to and including the next '#', which returns
// it to the idle state.
// ----------------------------------------------------------------------------
module ascii_bus_command_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [31:0] address_chars, [39:32] data_byte,
                                        // [43:40] data_index, [47:44] zero
    output logic [1:0]       m_tuser,   // [1:0] cmd_kind
    output logic             m_tlast    // last
);
    import abcp_pkg::*;

    abcp_cmd_t          cmd;
    abcp_stat_t         stat;
    kind_t              out_kind;
    logic [ADDR_W-1:0]  out_addr;
    logic [CHAR_W-1:0]  out_data;
    logic [INDEX_W-1:0] out_index;

    // The controller owns the parse state and the counters; it decides which
    // datapath registers are written for every accepted character.
    abcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath classifies the character, holds the address, the byte
    // being assembled and the sequence buffer, and drives the output register.
    abcp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_char   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_addr  (out_addr),
        .out_data  (out_data),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_index, out_data, out_addr};
    assign m_tuser = out_kind;

    // A word that is not the last of its command is taken while the drain
    // still runs, so the slave side must stay closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("slave side open while a command still drains");

    // Once the last word is loaded the parser must reopen the slave side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> s_tready)
        else $error("slave side still closed after the final word");

    // Only a write sequence carries a nonzero byte position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_index != '0)) |-> (out_kind == KIND_WS))
        else $error("byte position set on a single byte command");

    // A new word is loaded only when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.out_load)
        else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

### hw/rtl/abcp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII bus command parser datapath
// Character classification, address store, byte accumulator, sequence
// buffer and the output register.
// ----------------------------------------------------------------------------
module abcp_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [abcp_pkg::CHAR_W-1:0] rx_char,
    input  wire abcp_pkg::abcp_cmd_t         cmd,
    output abcp_pkg::abcp_stat_t             stat,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output abcp_pkg::kind_t                  out_kind,
    output logic [abcp_pkg::ADDR_W-1:0]      out_addr,
    output logic [abcp_pkg::CHAR_W-1:0]      out_data,
    output logic [abcp_pkg::INDEX_W-1:0]     out_index,
    output logic                             out_last
);
    import abcp_pkg::*;

    logic [CHAR_W-1:0] addr_store_reg [ADDR_CHARS];
    logic [CHAR_W-1:0] accum_reg;
    logic [CHAR_W-1:0] seq_mem [SEQ_BYTES];
    logic [CHAR_W-1:0] nib;
    logic [CHAR_W-1:0] sum;
    logic [ADDR_W-1:0] packed_addr;

    logic              valid_reg;
    kind_t             kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CHAR_W-1:0] data_reg;
    logic [INDEX_W-1:0] index_reg;
    logic              last_reg;

    assign nib = hex_value(rx_char);
    assign sum = accum_reg + nib;

    always_comb
    begin
        stat.is_r     = (rx_char == CH_R);
        stat.is_w     = (rx_char == CH_W);
        stat.is_b     = (rx_char == CH_B);
        stat.is_s     = (rx_char == CH_S);
        stat.is_comma = (rx_char == CH_COMMA);
        stat.is_hash  = (rx_char == CH_HASH);
        stat.out_free = !valid_reg || out_ready;
    end

    // First address character ends up in the most significant byte.
    always_comb
    begin
        packed_addr = '0;
        for (int i = 0; i < ADDR_CHARS; i++)
        begin
            packed_addr = {packed_addr[ADDR_W-CHAR_W-1:0], addr_store_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ADDR_CHARS; i++)
            begin
                addr_store_reg[i] <= '0;
            end
            accum_reg <= '0;
        end
        else
        begin
            if (cmd.addr_we)
            begin
                addr_store_reg[cmd.addr_idx] <= rx_char;
            end
            if (cmd.load_hi)
            begin
                accum_reg <= {nib[3:0], 4'b0000};
            end
            else if (cmd.add_lo)
            begin
                accum_reg <= sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_we)
        begin
            seq_mem[cmd.buf_idx] <= sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg  <= cmd.out_kind;
            addr_reg  <= packed_addr;
            index_reg <= cmd.out_index;
            last_reg  <= cmd.out_last;
            case (cmd.out_kind)
                KIND_WS: data_reg <= seq_mem[cmd.buf_idx];
                KIND_RB: data_reg <= '0;
                default: data_reg <= accum_reg;
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_addr  = addr_reg;
    assign out_data  = data_reg;
    assign out_index = index_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

### hw/rtl/abcp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII bus command parser controller
// Command state machine, character counters and the result drain sequencer.
// ----------------------------------------------------------------------------
module abcp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire abcp_pkg::abcp_stat_t stat,
    output abcp_pkg::abcp_cmd_t       cmd
);
    import abcp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_GOT_R = 9'b000000010,
        ST_GOT_W = 9'b000000100,
        ST_RB    = 9'b000001000,
        ST_RS    = 9'b000010000,
        ST_WB    = 9'b000100000,
        ST_WS    = 9'b001000000,
        ST_WAIT  = 9'b010000000,
        ST_DRAIN = 9'b100000000
    } state_t;

    localparam logic [ADDR_CNT_W-1:0] ADDR_FULL = ADDR_CNT_W'(ADDR_CHARS);
    localparam logic [ADDR_CNT_W-1:0] ADDR_LAST = ADDR_CNT_W'(ADDR_CHARS - 1);
    localparam logic [SEQ_IDX_W-1:0]  SEQ_LAST  = SEQ_IDX_W'(SEQ_BYTES - 1);

    state_t                 state_reg, state_next;
    logic [ADDR_CNT_W-1:0]  addr_count_reg, addr_count_next;
    logic                   comma_reg, comma_next;
    logic [1:0]             phase_reg, phase_next;
    logic [SEQ_IDX_W-1:0]   byte_count_reg, byte_count_next;
    logic [SEQ_IDX_W-1:0]   drain_idx_reg, drain_idx_next;
    kind_t                  kind_reg, kind_next;
    logic                   accept;
    logic [SEQ_IDX_W-1:0]   drain_end;
    logic                   addr_room;

    assign in_ready  = (state_reg != ST_DRAIN);
    assign accept    = in_valid && in_ready;
    assign drain_end = (kind_reg == KIND_WS) ? SEQ_LAST : '0;
    assign addr_room = (addr_count_reg < ADDR_FULL);

    always_comb
    begin
        state_next      = state_reg;
        addr_count_next = addr_count_reg;
        comma_next      = comma_reg;
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        drain_idx_next  = drain_idx_reg;
        kind_next       = kind_reg;

        cmd           = '0;
        cmd.addr_idx  = addr_count_reg[ADDR_IDX_W-1:0];
        cmd.buf_idx   = byte_count_reg;
        cmd.out_kind  = kind_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.is_r)
                begin
                    state_next = ST_GOT_R;
                end
                else if (accept && stat.is_w)
                begin
                    state_next = ST_GOT_W;
                end
            end
            ST_GOT_R, ST_GOT_W:
            begin
                if (accept)
                begin
                    comma_next      = 1'b0;
                    phase_next      = '0;
                    byte_count_next = '0;
                    if (stat.is_b || stat.is_s)
                    begin
                        addr_count_next = '0;
                        if (state_reg == ST_GOT_R)
                        begin
                            state_next = stat.is_b ? ST_RB : ST_RS;
                        end
                        else
                        begin
                            state_next = stat.is_b ? ST_WB : ST_WS;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RB:
            begin
                if (accept)
                begin
                    cmd.addr_we     = addr_room;
                    addr_count_next = addr_count_reg + 1'b1;
                    if (addr_count_reg == ADDR_LAST)
                    begin
                        kind_next      = KIND_RB;
                        drain_idx_next = '0;
                        state_next     = ST_DRAIN;
                    end
                end
            end
            ST_RS, ST_WB, ST_WS:
            begin
                if (accept)
                begin
                    if (!comma_reg)
                    begin
                        if (addr_room)
                        begin
                            cmd.addr_we     = 1'b1;
                            addr_count_next = addr_count_reg + 1'b1;
                        end
                        else if (stat.is_comma)
                        begin
                            comma_next = 1'b1;
                        end
                    end
                    else if (phase_reg == 2'd0)
                    begin
                        cmd.load_hi = 1'b1;
                        phase_next  = 2'd1;
                    end
                    else if (state_reg != ST_WS)
                    begin
                        // Second digit of the single byte completes the command.
                        cmd.add_lo     = 1'b1;
                        comma_next     = 1'b0;
                        phase_next     = '0;
                        kind_next      = (state_reg == ST_RS) ? KIND_RS : KIND_WB;
                        drain_idx_next = '0;
                        state_next     = ST_DRAIN;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        cmd.add_lo = 1'b1;
                        cmd.buf_we = 1'b1;
                        phase_next = 2'd2;
                    end
                    else if (byte_count_reg != SEQ_LAST)
                    begin
                        if (stat.is_comma)
                        begin
                            phase_next      = '0;
                            byte_count_next = byte_count_reg + 1'b1;
                        end
                        else
                        begin
                            comma_next      = 1'b0;
                            phase_next      = '0;
                            byte_count_next = '0;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        // Any character after the final byte completes the sequence.
                        comma_next      = 1'b0;
                        phase_next      = '0;
                        byte_count_next = '0;
                        kind_next       = KIND_WS;
                        drain_idx_next  = '0;
                        state_next      = ST_DRAIN;
                    end
                end
            end
            ST_WAIT:
            begin
                if (accept && stat.is_hash)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                cmd.buf_idx   = drain_idx_reg;
                cmd.out_index = (kind_reg == KIND_WS) ? INDEX_W'(drain_idx_reg) : '0;
                cmd.out_last  = (drain_idx_reg == drain_end);
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (drain_idx_reg == drain_end)
                    begin
                        drain_idx_next = '0;
                        state_next     = ST_WAIT;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_count_reg <= '0;
            comma_reg      <= 1'b0;
            phase_reg      <= '0;
            byte_count_reg <= '0;
            drain_idx_reg  <= '0;
            kind_reg       <= KIND_RB;
        end
        else
        begin
            state_reg      <= state_next;
            addr_count_reg <= addr_count_next;
            comma_reg      <= comma_next;
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            drain_idx_reg  <= drain_idx_next;
            kind_reg       <= kind_next;
        end
    end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// ASCII bus command parser testbench
// Streams character words into the parser, hand-picked ones first and then
// random well-formed, broken and noisy commands, with random gaps and
// backpressure on both sides. Every result word is checked field by field
// against a cycle-free model of the parser kept in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abcp_pkg::*;

    // Random characters after the directed part.
    localparam int RANDOM_CHARS = 320;
    // Quiet cycles tolerated before the run is declared hung. The longest
    // legitimate quiet stretch is one long sender gap or one long receiver
    // stall, so this is many times over.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles to watch for stray result words once nothing is expected. A WS
    // drain is sixteen words, so this covers a full drain with slack.
    localparam int TAIL_CYCLES  = 40;

    // Where the parser stands between characters.
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_GOT_R,
        PS_GOT_W,
        PS_RB,
        PS_RS,
        PS_WB,
        PS_WS,
        PS_WAIT
    } parser_state_t;

    // How a random command is damaged, if at all.
    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_LETTER,
        FLAW_COMMA,
        FLAW_NOISE
    } flaw_t;

    // One result word as the parser should produce it.
    typedef struct {
        kind_t       kind;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [3:0]  index;
        logic        last;
    } bus_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: follows the parser one character at a time and keeps the
    // result words it owes, oldest first.
    // ------------------------------------------------------------------------
    class cmd_scoreboard;
        parser_state_t state;
        int            addr_fill;
        logic [7:0]    addr_chars [ADDR_CHARS];
        bit            comma_seen;
        int            digit_phase;
        int            byte_pos;
        logic [7:0]    byte_accum;
        logic [7:0]    seq_bytes [SEQ_BYTES];
        bus_word_t     owed_words [$];
        int            errors;
        int            chars_seen;
        int            words_checked;
        int            abandoned;
        int            finished [4];

        function new();
            state       = PS_IDLE;
            addr_fill   = 0;
            comma_seen  = 0;
            digit_phase = 0;
            byte_pos    = 0;
            byte_accum  = '0;
            foreach (addr_chars[i]) addr_chars[i] = '0;
            foreach (seq_bytes[i]) seq_bytes[i] = '0;
            foreach (finished[i]) finished[i] = 0;
        endfunction

        function int outstanding();
            return owed_words.size();
        endfunction

        // Hex digit value without any validation; wraps modulo 256.
        function logic [7:0] nibble(logic [7:0] c);
            return c - ((c > CH_NINE) ? OFS_LETTER : OFS_DIGIT);
        endfunction

        // Takes the character as an address character while there is room.
        function bit absorb_address(logic [7:0] c);
            if (addr_fill < ADDR_CHARS)
            begin
                addr_chars[addr_fill] = c;
                addr_fill++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void drop_command();
            state       = PS_IDLE;
            comma_seen  = 0;
            digit_phase = 0;
            byte_pos    = 0;
            abandoned++;
        endfunction

        function void queue_word(kind_t kind, logic [7:0] data, logic [3:0] index,
                                 logic last);
            bus_word_t w;
            int        i;
            w.kind  = kind;
            w.addr  = '0;
            w.data  = data;
            w.index = index;
            w.last  = last;
            // First character ends up in the top byte.
            for (i = 0; i < ADDR_CHARS; i++)
                w.addr = {w.addr[ADDR_W-9:0], addr_chars[i]};
            owed_words.push_back(w);
            if (last)
                finished[kind]++;
        endfunction

        // Advances the model by one accepted character word.
        function void take_char(logic [7:0] c);
            int k;
            chars_seen++;
            case (state)
                PS_IDLE:
                begin
                    if (c == CH_R)
                        state = PS_GOT_R;
                    else if (c == CH_W)
                        state = PS_GOT_W;
                end
                PS_GOT_R, PS_GOT_W:
                begin
                    if (c == CH_B || c == CH_S)
                    begin
                        addr_fill   = 0;
                        comma_seen  = 0;
                        digit_phase = 0;
                        byte_pos    = 0;
                        if (state == PS_GOT_R)
                            state = (c == CH_B) ? PS_RB : PS_RS;
                        else
                            state = (c == CH_B) ? PS_WB : PS_WS;
                    end
                    else
                        drop_command();
                end
                PS_RB:
                begin
                    void'(absorb_address(c));
                    if (addr_fill >= ADDR_CHARS)
                    begin
                        state = PS_WAIT;
                        queue_word(KIND_RB, 8'h00, 4'd0, 1'b1);
                    end
                end
                PS_RS, PS_WB:
                begin
                    // An early comma is just another address character; junk
                    // between the address and the comma is dropped.
                    if (!comma_seen)
                    begin
                        if (!absorb_address(c) && c == CH_COMMA)
                            comma_seen = 1;
                    end
                    else if (digit_phase == 0)
                    begin
                        byte_accum  = nibble(c) << 4;
                        digit_phase = 1;
                    end
                    else
                    begin
                        byte_accum = byte_accum + nibble(c);
                        queue_word((state == PS_RS) ? KIND_RS : KIND_WB, byte_accum,
                                   4'd0, 1'b1);
                        comma_seen  = 0;
                        digit_phase = 0;
                        state       = PS_WAIT;
                    end
                end
                PS_WS:
                begin
                    if (!comma_seen)
                    begin
                        if (!absorb_address(c) && c == CH_COMMA)
                            comma_seen = 1;
                    end
                    else if (digit_phase == 0)
                    begin
                        seq_bytes[byte_pos] = nibble(c) << 4;
                        digit_phase = 1;
                    end
                    else if (digit_phase == 1)
                    begin
                        seq_bytes[byte_pos] = seq_bytes[byte_pos] + nibble(c);
                        digit_phase = 2;
                    end
                    else if (byte_pos < SEQ_BYTES - 1)
                    begin
                        // A separator other than a comma abandons the sequence.
                        if (c == CH_COMMA)
                        begin
                            digit_phase = 0;
                            byte_pos++;
                        end
                        else
                            drop_command();
                    end
                    else
                    begin
                        // Character after the last byte closes the command,
                        // whatever it is.
                        for (k = 0; k < SEQ_BYTES; k++)
                            queue_word(KIND_WS, seq_bytes[k], 4'(k), k == SEQ_BYTES - 1);
                        comma_seen  = 0;
                        digit_phase = 0;
                        byte_pos    = 0;
                        state       = PS_WAIT;
                    end
                end
                default:
                begin
                    if (c == CH_HASH)
                        state = PS_IDLE;
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
            $display("[%0t] mismatch on result word %0d, %s: got %0h, expected %0h",
                     $time, words_checked, what, got, exp_val);
            errors++;
        endtask

        // Compares one accepted result word with the oldest word owed.
        task check_word(logic [47:0] word, logic [1:0] user, logic tlast);
            bus_word_t want;
            if (owed_words.size() == 0)
            begin
                report_mismatch("word with nothing owed, address", word[31:0], '0);
                return;
            end
            want = owed_words.pop_front();
            words_checked++;
            if (user !== want.kind)
                report_mismatch("cmd_kind", user, want.kind);
            if (word[31:0] !== want.addr)
                report_mismatch("address_chars", word[31:0], want.addr);
            if (word[39:32] !== want.data)
                report_mismatch("data_byte", word[39:32], want.data);
            if (word[43:40] !== want.index)
                report_mismatch("data_index", word[43:40], want.index);
            if (word[47:44] !== 4'b0000)
                report_mismatch("pad bits", word[47:44], '0);
            if (tlast !== want.last)
                report_mismatch("last", tlast, want.last);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_char
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [31:0] address_chars, [39:32] data_byte,
                            // [43:40] data_index, [47:44] zero
    logic [1:0]  m_tuser;   // [1:0] cmd_kind
    logic        m_tlast;   // last

    cmd_scoreboard sb;
    // While set, neither side inserts gaps or stalls.
    bit            steady;

    ascii_bus_command_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly hex digits in either case, sometimes any byte at all.
    function automatic logic [7:0] hex_char();
        int v;
        if ($urandom_range(0, 9) < 2)
            return 8'($urandom_range(0, 255));
        v = $urandom_range(0, 21);
        if (v < 10)
            return OFS_DIGIT + 8'(v);
        if (v < 16)
            return OFS_LETTER + 8'(v);
        return OFS_LETTER + 8'd32 + 8'(v - 6);
    endfunction

    // Any byte but the one given.
    function automatic logic [7:0] any_but(logic [7:0] banned);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == banned) ? c ^ 8'h01 : c;
    endfunction

    // Line noise that cannot start a command from idle.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_R || c == CH_W) ? c ^ 8'h01 : c;
    endfunction

    // Offers one character word and returns at the falling edge after it was
    // taken. Called and returning at a falling edge; tvalid stays high between
    // back-to-back words.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_char(c);
        @(negedge clk);
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_char(text[i]);
    endtask

    // Holds the sender off until every owed result word has been taken.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // Sends one command with random content, damaged as the flaw asks, and, if
    // undamaged, the '#' that rearms the parser after a completed command.
    task automatic send_cmd(input kind_t kind, input flaw_t flaw);
        int i;
        int junk;
        int bad_pos;
        int nbytes;
        logic [7:0] c;
        send_char((kind == KIND_RB || kind == KIND_RS) ? CH_R : CH_W);
        if (flaw == FLAW_LETTER)
        begin
            c = 8'($urandom_range(0, 255));
            send_char((c == CH_B || c == CH_S) ? CH_HASH : c);
            return;
        end
        send_char((kind == KIND_RB || kind == KIND_WB) ? CH_B : CH_S);
        repeat (ADDR_CHARS) send_char(hex_char());
        if (kind != KIND_RB)
        begin
            junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (junk) send_char(any_but(CH_COMMA));
            send_char(CH_COMMA);
            bad_pos = (flaw == FLAW_COMMA) ? $urandom_range(0, SEQ_BYTES - 2) : SEQ_BYTES;
            nbytes  = (kind == KIND_WS) ? SEQ_BYTES : 1;
            for (i = 0; i < nbytes; i++)
            begin
                send_char(hex_char());
                send_char(hex_char());
                if (kind == KIND_WS)
                begin
                    if (i == bad_pos)
                    begin
                        send_char(any_but(CH_COMMA));
                        return;
                    end
                    send_char((i < SEQ_BYTES - 1) ? CH_COMMA : 8'($urandom_range(0, 255)));
                end
            end
        end
        // Characters after completion are ignored up to the '#'.
        repeat ($urandom_range(0, 2)) send_char(any_but(CH_HASH));
        send_char(CH_HASH);
    endtask

    // Receiver: random stalls, with runs of steady readiness in between.
    initial
    begin : result_sink
        int hold;
        m_tready = 1'b0;
        hold     = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (m_tready && !steady)
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    m_tready = 1'b0;
                    hold--;
                end
                else
                    hold = $urandom_range(0, 6);
            end
            else
            begin
                m_tready = 1'b1;
                hold     = $urandom_range(0, 10);
            end
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser, m_tlast);
    end

    // Ends the run if neither side moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word moved for %0d cycles, %0d result words still owed",
                 quiet, sb.outstanding());
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int    r;
        int    target;
        kind_t kind;
        flaw_t flaw;

        sb       = new();
        steady   = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Idle ignores anything that is not R or W, including the data extremes.
        send_char(8'h00);
        send_char(8'hFF);
        send_text("#B,S");
        // Bad second letters fall back to idle.
        send_text("RXWWRR");
        // RB with extreme and odd address characters; the parser then ignores
        // a whole command until the '#'.
        send_text("RB");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_COMMA);
        send_char(8'h7F);
        send_text("RSWB#");
        // RS with a comma inside the address and junk before the real comma.
        send_text("RS1,23zz,9A#");
        // WB whose digits are the byte extremes, which decode without checks.
        send_text("WBFFFF,");
        send_char(8'h00);
        send_char(8'hFF);
        send_text("#");
        // Full WS closed by a '#', which is consumed and does not rearm.
        send_text("WS1234,00,09,0A,0F,10,90,A0,F0,FF,ff,af,Z!,12,34,56,78##");
        wait_drained();
        // WS abandoned on a missing separator, then an RB built of separators.
        send_text("WSABCD,12,34;");
        send_text("RB#,#,#");
        wait_drained();

        // Random part: mostly well-formed commands with random content, plus
        // broken letters, broken separators and bare line noise.
        target = sb.chars_seen + RANDOM_CHARS;
        while (sb.chars_seen < target)
        begin
            steady = ($urandom_range(0, 5) == 0);
            r      = $urandom_range(0, 9);
            kind   = kind_t'($urandom_range(0, 3));
            if (r == 0)
                flaw = FLAW_LETTER;
            else if (r == 1)
                flaw = FLAW_NOISE;
            else if (r == 2 && kind == KIND_WS)
                flaw = FLAW_COMMA;
            else
                flaw = FLAW_NONE;
            if (flaw == FLAW_NOISE)
                repeat ($urandom_range(1, 6)) send_char(noise_char());
            else
                send_cmd(kind, flaw);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        steady = 1'b0;

        // Collect the last words, then watch for strays.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d characters and %0d result words, %0d mismatches",
                 sb.chars_seen, sb.words_checked, sb.errors);
        $display("commands completed: RB %0d, RS %0d, WB %0d, WS %0d; %0d abandoned",
                 sb.finished[KIND_RB], sb.finished[KIND_RS], sb.finished[KIND_WB],
                 sb.finished[KIND_WS], sb.abandoned);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/abcp_pkg.sv
hw/rtl/abcp_datapath.sv
hw/rtl/abcp_ctrl.sv
hw/rtl/ascii_bus_command_parser.sv
tb/sv/testbench.sv
